@@ hdl/cbmr_pkg.sv @@
// ----------------------------------------------------------------------------
// cbmr_pkg
// Shared types and constants of the cartridge bank mapper with real-time
// clock: request and result items, clock command and clock time groups.
// ----------------------------------------------------------------------------
package cbmr_pkg;

    // default bank address widths
    localparam int ROM_BANK_BITS_DEF = 7;
    localparam int RAM_BANK_BITS_DEF = 2;

    // clock counts at this rate
    localparam logic [20:0] TICKS_PER_SECOND = 21'd1048576;
    localparam logic [5:0]  SECOND_LIMIT     = 6'd60;
    localparam logic [5:0]  MINUTE_LIMIT     = 6'd60;
    localparam logic [4:0]  HOUR_LIMIT       = 5'd24;

    // enable key that opens the A000-BFFF window
    localparam logic [3:0] ENABLE_KEY = 4'hA;

    // ram/clock select codes
    localparam logic [7:0] SEL_RAM_LAST = 8'h03;
    localparam logic [7:0] SEL_SECONDS  = 8'h08;
    localparam logic [7:0] SEL_MINUTES  = 8'h09;
    localparam logic [7:0] SEL_HOURS    = 8'h0A;
    localparam logic [7:0] SEL_DAY_LO   = 8'h0B;
    localparam logic [7:0] SEL_DAY_HI   = 8'h0C;

    localparam logic [7:0] OPEN_BUS   = 8'hFF;
    localparam logic [7:0] LATCH_ARM  = 8'h00;
    localparam logic [7:0] LATCH_FIRE = 8'h01;

    // configuration register indexes
    localparam logic [0:0] CFG_ROM_LIMIT = 1'b0;
    localparam logic [0:0] CFG_RAM_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NOP   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_ROM_RD = 2'd1,
        KIND_RAM_RD = 2'd2,
        KIND_RAM_WR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        FLD_NONE    = 3'd0,
        FLD_SECONDS = 3'd1,
        FLD_MINUTES = 3'd2,
        FLD_HOURS   = 3'd3,
        FLD_DAY_LO  = 3'd4,
        FLD_DAY_HI  = 3'd5
    } rtc_field_t;

    typedef struct packed {
        req_type_t   req_type;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
        logic [7:0]  tick_cycles;
    } req_item_t;

    typedef struct packed {
        kind_t       target_kind;
        logic [20:0] mem_address;
        logic [7:0]  read_value;
        logic [7:0]  mem_write_value;
    } rsp_item_t;

    // command from the bus decoder to the clock
    typedef struct packed {
        logic        tick;
        logic [7:0]  cycles;
        rtc_field_t  wr_field;
        logic [7:0]  wr_data;
        logic        latch;
    } rtc_cmd_t;

    // clock time fields
    typedef struct packed {
        logic        halt;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [8:0]  days;
        logic        carry;
    } rtc_time_t;

endpackage

@@ hdl/cbmr_if.sv @@
// ----------------------------------------------------------------------------
// cbmr interfaces
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface cbmr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
    logic [7:0]  tick_cycles;

    modport source (output valid, req_type, bus_address, bus_data, tick_cycles,
                    input ready);
    modport sink   (input valid, req_type, bus_address, bus_data, tick_cycles,
                    output ready);
endinterface

interface cbmr_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  target_kind;
    logic [20:0] mem_address;
    logic [7:0]  read_value;
    logic [7:0]  mem_write_value;

    modport source (output valid, target_kind, mem_address, read_value,
                    mem_write_value, input ready);
    modport sink   (input valid, target_kind, mem_address, read_value,
                    mem_write_value, output ready);
endinterface

interface cbmr_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [6:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/cbmr_rtc.sv @@
// ----------------------------------------------------------------------------
// cbmr_rtc
// Real-time clock: sub-second counter, seconds/minutes/hours/days chain,
// field writes and the latched copy read by the bus.
// ----------------------------------------------------------------------------
module cbmr_rtc (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  cbmr_pkg::rtc_cmd_t cmd,
    output cbmr_pkg::rtc_time_t held
);
    import cbmr_pkg::*;

    rtc_time_t   time_reg, time_next;
    rtc_time_t   held_reg, held_next;
    logic [20:0] sub_reg, sub_next;

    logic [21:0] sub_sum;
    logic [5:0]  sec_inc;
    logic [5:0]  min_inc;
    logic [4:0]  hour_inc;
    logic [9:0]  day_inc;

    assign sub_sum  = {1'b0, sub_reg} + 22'(cmd.cycles);
    assign sec_inc  = time_reg.seconds + 6'd1;
    assign min_inc  = time_reg.minutes + 6'd1;
    assign hour_inc = time_reg.hours + 5'd1;
    assign day_inc  = {1'b0, time_reg.days} + 10'd1;

    // next clock state
    always_comb
    begin
        time_next = time_reg;
        sub_next  = sub_reg;
        held_next = held_reg;
        if (cmd.tick && !time_reg.halt)
        begin
            // chain stops at the first field that does not roll over
            if (sub_sum >= 22'(TICKS_PER_SECOND))
            begin
                sub_next = 21'(sub_sum - 22'(TICKS_PER_SECOND));
                time_next.seconds = sec_inc;
                if (sec_inc == SECOND_LIMIT)
                begin
                    time_next.seconds = '0;
                    time_next.minutes = min_inc;
                    if (min_inc == MINUTE_LIMIT)
                    begin
                        time_next.minutes = '0;
                        time_next.hours   = hour_inc;
                        if (hour_inc == HOUR_LIMIT)
                        begin
                            time_next.hours = '0;
                            if (day_inc[9])
                            begin
                                time_next.days  = '0;
                                time_next.carry = 1'b1;
                            end
                            else
                            begin
                                time_next.days = day_inc[8:0];
                            end
                        end
                    end
                end
            end
            else
            begin
                sub_next = sub_sum[20:0];
            end
        end
        // field writes
        unique case (cmd.wr_field)
            FLD_SECONDS:
            begin
                time_next.seconds = cmd.wr_data[5:0];
                sub_next          = '0;
            end
            FLD_MINUTES: time_next.minutes = cmd.wr_data[5:0];
            FLD_HOURS:   time_next.hours   = cmd.wr_data[4:0];
            FLD_DAY_LO:  time_next.days    = {time_reg.days[8], cmd.wr_data};
            FLD_DAY_HI:
            begin
                time_next.days  = {cmd.wr_data[0], time_reg.days[7:0]};
                time_next.halt  = cmd.wr_data[6];
                time_next.carry = cmd.wr_data[7];
            end
            default: ;
        endcase
        // latch copy
        if (cmd.latch)
        begin
            held_next = time_reg;
        end
    end

    // clock registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            held_reg <= '0;
            sub_reg  <= '0;
        end
        else if (fire)
        begin
            time_reg <= time_next;
            held_reg <= held_next;
            sub_reg  <= sub_next;
        end
    end

    assign held = held_reg;

endmodule

@@ hdl/cbmr_decode.sv @@
// ----------------------------------------------------------------------------
// cbmr_decode
// Bus decoder and mapper registers: maps reads and writes to ROM, RAM or
// clock, keeps enable, bank and latch registers, issues clock commands.
// ----------------------------------------------------------------------------
module cbmr_decode #(
    parameter int ROM_BANK_BITS = cbmr_pkg::ROM_BANK_BITS_DEF,
    parameter int RAM_BANK_BITS = cbmr_pkg::RAM_BANK_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  cbmr_pkg::req_item_t item,
    input  logic [6:0]          rom_limit,
    input  logic [1:0]          ram_limit,
    input  cbmr_pkg::rtc_time_t held,
    output cbmr_pkg::rsp_item_t result,
    output cbmr_pkg::rtc_cmd_t  rtc_cmd
);
    import cbmr_pkg::*;

    localparam logic [6:0] ROM_WMASK = 7'((1 << ROM_BANK_BITS) - 1);
    localparam logic [1:0] RAM_WMASK = 2'((1 << RAM_BANK_BITS) - 1);

    logic [3:0] enable_reg, enable_next;
    logic [6:0] rom_sel_reg, rom_sel_next;
    logic [7:0] ram_sel_reg, ram_sel_next;
    logic [7:0] latch_reg, latch_next;

    logic       in_rom0, in_romx, in_ram;
    logic       enabled, ram_mapped;
    logic [6:0] rom_bank;
    logic [1:0] ram_bank;
    logic [7:0] clock_value;

    assign in_rom0    = (item.bus_address[15:14] == 2'b00);
    assign in_romx    = (item.bus_address[15:14] == 2'b01);
    assign in_ram     = (item.bus_address[15:13] == 3'b101);
    assign enabled    = (enable_reg == ENABLE_KEY);
    assign ram_mapped = (ram_sel_reg <= SEL_RAM_LAST);

    // bank selection, with a ROM bank of zero taken as one
    assign rom_bank = ((rom_sel_reg == 7'd0) ? 7'd1 : rom_sel_reg) & rom_limit & ROM_WMASK;
    assign ram_bank = ram_sel_reg[1:0] & ram_limit & RAM_WMASK;

    // latched clock read
    always_comb
    begin
        unique case (ram_sel_reg)
            SEL_SECONDS: clock_value = {2'b00, held.seconds};
            SEL_MINUTES: clock_value = {2'b00, held.minutes};
            SEL_HOURS:   clock_value = {3'b000, held.hours};
            SEL_DAY_LO:  clock_value = held.days[7:0];
            SEL_DAY_HI:  clock_value = {held.carry, held.halt, 5'b00000, held.days[8]};
            default:     clock_value = OPEN_BUS;
        endcase
    end

    // decode of one transaction
    always_comb
    begin
        result       = '0;
        rtc_cmd      = '0;
        enable_next  = enable_reg;
        rom_sel_next = rom_sel_reg;
        ram_sel_next = ram_sel_reg;
        latch_next   = latch_reg;
        unique case (item.req_type)
            REQ_READ:
            begin
                if (in_rom0)
                begin
                    result.target_kind = KIND_ROM_RD;
                    result.mem_address = {5'd0, item.bus_address};
                end
                else if (in_romx)
                begin
                    result.target_kind = KIND_ROM_RD;
                    result.mem_address = {rom_bank, item.bus_address[13:0]};
                end
                else if (in_ram)
                begin
                    if (!enabled)
                    begin
                        result.read_value = OPEN_BUS;
                    end
                    else if (ram_mapped)
                    begin
                        result.target_kind = KIND_RAM_RD;
                        result.mem_address = {6'd0, ram_bank, item.bus_address[12:0]};
                    end
                    else
                    begin
                        result.read_value = clock_value;
                    end
                end
            end
            REQ_WRITE:
            begin
                unique case (item.bus_address[15:13])
                    3'b000: enable_next  = item.bus_data[3:0];
                    3'b001: rom_sel_next = item.bus_data[6:0];
                    3'b010,
                    3'b011: ram_sel_next = item.bus_data;
                    3'b100,
                    3'b111,
                    3'b110: ;
                    3'b101:
                    begin
                        if (enabled && ram_mapped)
                        begin
                            result.target_kind     = KIND_RAM_WR;
                            result.mem_address     = {6'd0, ram_bank, item.bus_address[12:0]};
                            result.mem_write_value = item.bus_data;
                        end
                        else if (enabled)
                        begin
                            unique case (ram_sel_reg)
                                SEL_SECONDS: rtc_cmd.wr_field = FLD_SECONDS;
                                SEL_MINUTES: rtc_cmd.wr_field = FLD_MINUTES;
                                SEL_HOURS:   rtc_cmd.wr_field = FLD_HOURS;
                                SEL_DAY_LO:  rtc_cmd.wr_field = FLD_DAY_LO;
                                SEL_DAY_HI:  rtc_cmd.wr_field = FLD_DAY_HI;
                                default:     rtc_cmd.wr_field = FLD_NONE;
                            endcase
                            rtc_cmd.wr_data = item.bus_data;
                        end
                    end
                    default: ;
                endcase
                // 6000-7FFF is the latch register, not the select
                if (item.bus_address[15:13] == 3'b011)
                begin
                    ram_sel_next  = ram_sel_reg;
                    rtc_cmd.latch = (item.bus_data == LATCH_FIRE) && (latch_reg == LATCH_ARM);
                    latch_next    = item.bus_data;
                end
            end
            REQ_TICK:
            begin
                rtc_cmd.tick   = 1'b1;
                rtc_cmd.cycles = item.tick_cycles;
            end
            REQ_NOP: ;
            default: ;
        endcase
    end

    // mapper registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= '0;
            rom_sel_reg <= 7'd1;
            ram_sel_reg <= '0;
            latch_reg   <= '0;
        end
        else if (fire)
        begin
            enable_reg  <= enable_next;
            rom_sel_reg <= rom_sel_next;
            ram_sel_reg <= ram_sel_next;
            latch_reg   <= latch_next;
        end
    end

endmodule

@@ hdl/cartridge_bank_mapper_rtc_unit.sv @@
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_rtc_unit
// Cartridge bank controller with real-time clock: bus decode, bank mapping
// and clock, with an input register and a result register.
// ----------------------------------------------------------------------------
// Each transaction (bus read, bus write, clock tick or no-op) is taken into
// an input register, then decoded and applied to the mapper and clock state
// as it moves to an output register, where its single result is held; a
// result is presented from the output register and can be taken at the
// following edge. One transaction is accepted every cycle as long as the
// result register drains; the rate is set by the decode and clock update
// between the two registers. ROM and RAM are external: results carry physical
// addresses. Configuration writes are taken at any time and must only be
// issued while no transaction is in flight.
module cartridge_bank_mapper_rtc_unit #(
    parameter int ROM_BANK_BITS = cbmr_pkg::ROM_BANK_BITS_DEF,
    parameter int RAM_BANK_BITS = cbmr_pkg::RAM_BANK_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    cbmr_req_if.sink  req,
    cbmr_rsp_if.source rsp,
    cbmr_cfg_if.sink  cfg
);
    import cbmr_pkg::*;

    logic       in_valid_reg;
    req_item_t  in_item_reg;
    logic       out_valid_reg;
    rsp_item_t  out_item_reg;
    logic [6:0] rom_limit_reg;
    logic [1:0] ram_limit_reg;

    logic       fire;
    logic       out_free;
    rsp_item_t  result;
    rtc_cmd_t   rtc_cmd;
    rtc_time_t  held;

    // handshake control
    assign out_free  = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || out_free;
    assign cfg.ready = 1'b1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg <= '{req_type:    req_type_t'(req.req_type),
                             bus_address: req.bus_address,
                             bus_data:    req.bus_data,
                             tick_cycles: req.tick_cycles};
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_item_reg <= result;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.target_kind     = out_item_reg.target_kind;
    assign rsp.mem_address     = out_item_reg.mem_address;
    assign rsp.read_value      = out_item_reg.read_value;
    assign rsp.mem_write_value = out_item_reg.mem_write_value;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_limit_reg <= 7'd127;
            ram_limit_reg <= 2'd3;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ROM_LIMIT: rom_limit_reg <= cfg.data;
                CFG_RAM_LIMIT: ram_limit_reg <= cfg.data[1:0];
                default: ;
            endcase
        end
    end

    cbmr_decode #(
        .ROM_BANK_BITS (ROM_BANK_BITS),
        .RAM_BANK_BITS (RAM_BANK_BITS)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_item_reg),
        .rom_limit (rom_limit_reg),
        .ram_limit (ram_limit_reg),
        .held      (held),
        .result    (result),
        .rtc_cmd   (rtc_cmd)
    );

    cbmr_rtc u_rtc (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .cmd   (rtc_cmd),
        .held  (held)
    );

`ifndef SYNTHESIS
    // a processed transaction always lands in the result register
    a_fire_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed transaction did not reach result register");

    // a waiting transaction is never dropped from the input register
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |=> in_valid_reg)
        else $error("input transaction lost while stalled");

    // clock ticks produce an empty result
    a_tick_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_item_reg.req_type == REQ_TICK) |=>
            (rsp.target_kind == KIND_NONE && rsp.read_value == 8'd0))
        else $error("clock tick produced a non-empty result");
`endif

endmodule
